FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the task slot queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define TSQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define TSQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Types and constants shared by the task slot queue modules.
// ----------------------------------------------------------------------------
package tsq_pkg;

  // Slot count is fixed by the 4-bit slot fields on the ports.
  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int PTR_W  = SLOT_W + 1;   // slot number or the none marker
  localparam int GEN_W  = 32;
  localparam int WORD_W = 64;

  // The none marker is the value SLOTS.
  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(SLOTS);

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOT_BUSY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_FREE    = 2'd0,
    PH_PENDING = 2'd1,
    PH_BUSY    = 2'd2
  } phase_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [SLOT_W-1:0]  slot_index;
    logic [GEN_W-1:0]   query_generation;
    logic [WORD_W-1:0]  proc_handle;
    logic [WORD_W-1:0]  arg_word;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [GEN_W-1:0]   generation;
    logic [WORD_W-1:0]  proc_word;
    logic [WORD_W-1:0]  arg_word;
    logic               finished;
  } result_t;

  // List occupancy flags exported by the engine for checking.
  typedef struct packed {
    logic free_none;
    logic pend_none;
    logic any_free;
    logic any_pend;
  } occ_t;

endpackage

FILE: design/tsq_in_stage.sv
// ----------------------------------------------------------------------------
// tsq_in_stage
// Input register: captures one command beat and holds it until executed.
// ----------------------------------------------------------------------------
module tsq_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tsq_pkg::item_t item,
  input  logic           advance,
  output logic           valid_r,
  output tsq_pkg::item_t item_r
);

  logic valid_nxt;
  logic load;

  // The held beat leaves when the engine executes it.
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

endmodule

FILE: design/tsq_engine.sv
// ----------------------------------------------------------------------------
// tsq_engine
// Slot table, free and pending list heads, and command execution.
// ----------------------------------------------------------------------------
module tsq_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  tsq_pkg::item_t   item,
  output tsq_pkg::result_t res_nxt,
  output tsq_pkg::occ_t    occ
);

  localparam int SLOTS  = tsq_pkg::SLOTS;
  localparam int SLOT_W = tsq_pkg::SLOT_W;
  localparam int PTR_W  = tsq_pkg::PTR_W;
  localparam int GEN_W  = tsq_pkg::GEN_W;
  localparam int WORD_W = tsq_pkg::WORD_W;

  localparam logic [PTR_W-1:0] NONE_LIMIT = tsq_pkg::NONE_PTR;

  logic [WORD_W-1:0]     slot_proc_r    [SLOTS];
  logic [WORD_W-1:0]     slot_arg_r     [SLOTS];
  logic [GEN_W-1:0]      slot_gen_r     [SLOTS];
  logic [PTR_W-1:0]      free_link_r    [SLOTS];
  logic [PTR_W-1:0]      pending_link_r [SLOTS];
  tsq_pkg::phase_t       slot_phase_r   [SLOTS];
  logic [PTR_W-1:0]      free_head_r;
  logic [PTR_W-1:0]      free_head_nxt;
  logic [PTR_W-1:0]      pending_head_r;
  logic [PTR_W-1:0]      pending_head_nxt;

  // Every command reads and writes at most one slot, so one address serves.
  logic [SLOT_W-1:0]     sel;
  logic                  free_ok;
  logic                  pend_ok;
  logic                  idx_ok;
  logic [GEN_W-1:0]      gen_rd;

  logic                  fl_we;
  logic [PTR_W-1:0]      fl_data;
  logic                  pl_we;
  logic [PTR_W-1:0]      pl_data;
  logic                  ph_we;
  tsq_pkg::phase_t       ph_data;
  logic                  gen_we;
  logic                  desc_we;

  assign free_ok = free_head_r < NONE_LIMIT;
  assign pend_ok = pending_head_r < NONE_LIMIT;
  assign idx_ok  = PTR_W'(item.slot_index) < NONE_LIMIT;

  always_comb begin
    unique case (item.cmd)
      tsq_pkg::CMD_ENQUEUE:  sel = free_head_r[SLOT_W-1:0];
      tsq_pkg::CMD_DISPATCH: sel = pending_head_r[SLOT_W-1:0];
      default:               sel = item.slot_index;
    endcase
  end

  assign gen_rd = slot_gen_r[sel];

  always_comb begin
    res_nxt            = '0;
    res_nxt.status     = tsq_pkg::ST_OK;
    free_head_nxt      = free_head_r;
    pending_head_nxt   = pending_head_r;
    fl_we              = 1'b0;
    fl_data            = tsq_pkg::NONE_PTR;
    pl_we              = 1'b0;
    pl_data            = tsq_pkg::NONE_PTR;
    ph_we              = 1'b0;
    ph_data            = tsq_pkg::PH_FREE;
    gen_we             = 1'b0;
    desc_we            = 1'b0;

    unique case (item.cmd)
      tsq_pkg::CMD_ENQUEUE: begin
        if (free_ok) begin
          free_head_nxt      = free_link_r[sel];
          fl_we              = 1'b1;
          pl_we              = 1'b1;
          pl_data            = pending_head_r;
          pending_head_nxt   = free_head_r;
          ph_we              = 1'b1;
          ph_data            = tsq_pkg::PH_PENDING;
          desc_we            = 1'b1;
          res_nxt.slot       = sel;
          res_nxt.generation = gen_rd;
        end else begin
          res_nxt.status     = tsq_pkg::ST_FULL;
        end
      end
      tsq_pkg::CMD_DISPATCH: begin
        if (pend_ok) begin
          pending_head_nxt   = pending_link_r[sel];
          pl_we              = 1'b1;
          ph_we              = 1'b1;
          ph_data            = tsq_pkg::PH_BUSY;
          res_nxt.slot       = sel;
          res_nxt.generation = gen_rd;
          res_nxt.proc_word  = slot_proc_r[sel];
          res_nxt.arg_word   = slot_arg_r[sel];
        end else begin
          res_nxt.status     = tsq_pkg::ST_EMPTY;
        end
      end
      tsq_pkg::CMD_COMPLETE: begin
        if (idx_ok && slot_phase_r[sel] == tsq_pkg::PH_BUSY) begin
          gen_we             = 1'b1;
          fl_we              = 1'b1;
          fl_data            = free_head_r;
          free_head_nxt      = PTR_W'(sel);
          ph_we              = 1'b1;
          ph_data            = tsq_pkg::PH_FREE;
          res_nxt.slot       = sel;
          res_nxt.generation = gen_rd;
        end else begin
          res_nxt.status     = tsq_pkg::ST_NOT_BUSY;
        end
      end
      default: begin
        if (idx_ok) begin
          res_nxt.slot       = sel;
          res_nxt.generation = gen_rd;
          res_nxt.finished   = gen_rd != item.query_generation;
        end else begin
          res_nxt.status     = tsq_pkg::ST_NOT_BUSY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r    <= '0;
      pending_head_r <= tsq_pkg::NONE_PTR;
      for (int i = 0; i < SLOTS; i++) begin
        // The last entry gets SLOTS, which is the none marker.
        free_link_r[i]    <= PTR_W'(i + 1);
        pending_link_r[i] <= tsq_pkg::NONE_PTR;
        slot_phase_r[i]   <= tsq_pkg::PH_FREE;
        slot_gen_r[i]     <= '0;
      end
    end else if (fire) begin
      free_head_r    <= free_head_nxt;
      pending_head_r <= pending_head_nxt;
      if (fl_we) begin
        free_link_r[sel] <= fl_data;
      end
      if (pl_we) begin
        pending_link_r[sel] <= pl_data;
      end
      if (ph_we) begin
        slot_phase_r[sel] <= ph_data;
      end
      if (gen_we) begin
        slot_gen_r[sel] <= gen_rd + GEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && desc_we) begin
      slot_proc_r[sel] <= item.proc_handle;
      slot_arg_r[sel]  <= item.arg_word;
    end
  end

  always_comb begin
    occ.free_none = !free_ok;
    occ.pend_none = !pend_ok;
    occ.any_free  = 1'b0;
    occ.any_pend  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      occ.any_free = occ.any_free | (slot_phase_r[i] == tsq_pkg::PH_FREE);
      occ.any_pend = occ.any_pend | (slot_phase_r[i] == tsq_pkg::PH_PENDING);
    end
  end

endmodule

FILE: design/tsq_out_stage.sv
// ----------------------------------------------------------------------------
// tsq_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module tsq_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tsq_pkg::result_t res_nxt,
  input  logic             out_stall,
  output logic             room,
  output logic             valid_r,
  output tsq_pkg::result_t res_r
);

  logic valid_nxt;

  // A new result may enter when the register is empty or is being drained.
  assign room = !valid_r || !out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: design/task_slot_queue_with_generations.sv
// ----------------------------------------------------------------------------
// task_slot_queue_with_generations
// Path: command beats go through the input register, then the output register.
// Throughput: one command per cycle while the consumer keeps up.
// Reset: synchronous, active low; all slots free, nothing pending, gens zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

// The block keeps a table of task slots. Free slots sit on a free stack and
// enqueued slots on a pending stack, both threaded through per-slot link
// fields, so a command touches at most the two list heads and one slot entry.
//
// Data flow: an accepted command beat is captured in the input register.
// Once the output has room, the engine executes it on the slot table, updates
// the list heads and the addressed slot, and the result is written into the
// output register. The input register is freed in the same cycle, so a new
// command can be accepted every cycle while the consumer keeps up. When the
// consumer stalls, the output register holds its beat, the engine stops,
// and the input register back-pressures the producer.
//
// Because each command's state update lands at the same edge that its
// result is registered, the next command always sees the updated lists.
module task_slot_queue_with_generations (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_slot_index,
  input  logic [31:0] in_query_generation,
  input  logic [63:0] in_proc_handle,
  input  logic [63:0] in_arg_word,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [31:0] out_generation,
  output logic [63:0] out_proc,
  output logic [63:0] out_arg,
  output logic        out_finished
);

  tsq_pkg::item_t   in_item;
  tsq_pkg::item_t   item_r;
  logic             item_valid_r;
  tsq_pkg::result_t res_nxt;
  tsq_pkg::result_t res_r;
  tsq_pkg::occ_t    occ;
  logic             room;
  logic             fire;

  // Pack the command beat into one word for the input register.
  always_comb begin
    in_item.cmd              = tsq_pkg::cmd_t'(in_cmd);
    in_item.slot_index       = in_slot_index;
    in_item.query_generation = in_query_generation;
    in_item.proc_handle      = in_proc_handle;
    in_item.arg_word         = in_arg_word;
  end

  // The held command executes whenever the output register can take its
  // result.
  assign fire = item_valid_r && room;

  tsq_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item     (in_item),
    .advance  (fire),
    .valid_r  (item_valid_r),
    .item_r   (item_r)
  );

  tsq_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item_r),
    .res_nxt (res_nxt),
    .occ     (occ)
  );

  tsq_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_nxt   (res_nxt),
    .out_stall (out_stall),
    .room      (room),
    .valid_r   (out_valid),
    .res_r     (res_r)
  );

  // Unpack the registered result onto the result ports.
  assign out_status     = res_r.status;
  assign out_slot       = res_r.slot;
  assign out_generation = res_r.generation;
  assign out_proc       = res_r.proc_word;
  assign out_arg        = res_r.arg_word;
  assign out_finished   = res_r.finished;

  // The free stack is empty exactly when no slot is in the free phase.
  `TSQ_ASSERT(a_free_list_consistent, clk, rst_n, occ.free_none == !occ.any_free,
              "free head disagrees with slot phases")
  // The pending stack is empty exactly when no slot is pending.
  `TSQ_ASSERT(a_pend_list_consistent, clk, rst_n, occ.pend_none == !occ.any_pend,
              "pending head disagrees with slot phases")
  // A held command with an empty result register must produce a result.
  `TSQ_ASSERT(a_no_lost_beat, clk, rst_n, item_valid_r && !out_valid |=> out_valid,
              "held command did not reach the result register")
  // Reset empties both the input and the result register.
  `TSQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !item_valid_r,
                     "pipeline not empty after reset")

endmodule
